/* rtl/scr_pkg.sv */
package scr_pkg;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_WRITE_TEXT = 2'd0,
    OP_WRITE_FONT = 2'd1,
    OP_RENDER     = 2'd2,
    OP_UNUSED     = 2'd3
  } scr_op_e;

  // Register indexes on the configuration port (paddr bit 2).
  localparam logic REG_TEXT_LENGTH  = 1'b0;
  localparam logic REG_MS_PER_PIXEL = 1'b1;

  localparam logic [6:0]  TEXT_LENGTH_RST  = 7'd1;
  localparam logic [15:0] MS_PER_PIXEL_RST = 16'd125;

  localparam int FONT_DEPTH = 2048;
  localparam int FONT_AW    = 11;
  localparam int FIFO_DEPTH = 4;

  // Fixed rainbow color of each glyph row, red in the top byte.
  localparam logic [23:0] ROW_PALETTE [0:7] = '{
    24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'h00FF00,
    24'h00FFFF, 24'h0000FF, 24'h8000FF, 24'hFF0080
  };

  typedef struct packed {
    logic [6:0]  text_length;
    logic [15:0] ms_per_pixel;
  } scr_cfg_t;

  typedef struct packed {
    logic [5:0] column;
    logic [7:0] mask;
    logic       last;
  } scr_entry_t;

endpackage

/* rtl/scr_chan_if.sv */
interface scr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [10:0] address;
  logic [7:0]  data;
  logic [31:0] timestamp_ms;

  modport source (output valid, output opcode, output address, output data,
                  output timestamp_ms, input ready);
  modport sink   (input valid, input opcode, input address, input data,
                  input timestamp_ms, output ready);
endinterface

interface scr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  column;
  logic [23:0] row0_rgb;
  logic [23:0] row1_rgb;
  logic [23:0] row2_rgb;
  logic [23:0] row3_rgb;
  logic [23:0] row4_rgb;
  logic [23:0] row5_rgb;
  logic [23:0] row6_rgb;
  logic [23:0] row7_rgb;
  logic        last_column;

  modport source (output valid, output column, output row0_rgb, output row1_rgb,
                  output row2_rgb, output row3_rgb, output row4_rgb, output row5_rgb,
                  output row6_rgb, output row7_rgb, output last_column, input ready);
  modport sink   (input valid, input column, input row0_rgb, input row1_rgb,
                  input row2_rgb, input row3_rgb, input row4_rgb, input row5_rgb,
                  input row6_rgb, input row7_rgb, input last_column, output ready);
endinterface

/* rtl/scr_ram.sv */
module scr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/scr_apb_regs.sv */
module scr_apb_regs
  import scr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output scr_cfg_t    cfg_o
);

  scr_cfg_t cfg_q;
  logic     wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_length  <= TEXT_LENGTH_RST;
      cfg_q.ms_per_pixel <= MS_PER_PIXEL_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TEXT_LENGTH:  cfg_q.text_length  <= pwdata[6:0];
        REG_MS_PER_PIXEL: cfg_q.ms_per_pixel <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TEXT_LENGTH:  prdata = {25'd0, cfg_q.text_length};
      REG_MS_PER_PIXEL: prdata = {16'd0, cfg_q.ms_per_pixel};
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/scr_divmod.sv */
module scr_divmod #(
  parameter int MOD_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [15:0]      divisor_i,
  input  logic [MOD_W-1:0] modulus_i,
  output logic             done_o,
  output logic [MOD_W-1:0] result_o
);

  // Restoring division, one quotient bit per cycle, most significant first.
  // Each quotient bit is folded into a running remainder modulo the modulus,
  // so the quotient itself is never stored.
  logic             busy_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [31:0]      dv_q;
  logic [15:0]      rem_q;
  logic [15:0]      div_q;
  logic [MOD_W-1:0] mod_q;
  logic [MOD_W-1:0] modulus_q;

  logic [16:0]      trial;
  logic             qbit;
  logic [15:0]      rem_d;
  logic [MOD_W:0]   m2;
  logic [MOD_W-1:0] mod_d;

  always_comb begin
    trial = {rem_q, dv_q[31]};
    qbit  = trial >= {1'b0, div_q};
    rem_d = qbit ? 16'(trial - {1'b0, div_q}) : trial[15:0];
    m2    = {mod_q, qbit};
    mod_d = (m2 >= {1'b0, modulus_q}) ? MOD_W'(m2 - {1'b0, modulus_q}) : m2[MOD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q      <= dividend_i;
      div_q     <= divisor_i;
      modulus_q <= modulus_i;
      rem_q     <= '0;
      mod_q     <= '0;
    end else if (busy_q) begin
      dv_q  <= {dv_q[30:0], 1'b0};
      rem_q <= rem_d;
      mod_q <= mod_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = mod_q;

endmodule

/* rtl/scrolling_text_column_renderer.sv */
// Channel   Direction  Transaction
// in_ch_i   in         one load (text character, font column mask) or one render
// out_ch_o  out        one grid column: index, eight row colors, last flag
// APB       in         write or read of text_length (0x0) and ms_per_pixel (0x4)
//
// A load item writes its store in the cycle it is accepted.
// A render item is accepted, then runs the bit-serial divider that yields the
// scroll offset, then starts the column sequencer, which fetches one column per
// cycle while the output queue has space, set by the single read port of each store.
// Reset clears control state only; both stores hold garbage until written.
// A stalled consumer fills the four-entry output queue; column fetches pause
// until space returns and resume without loss.
module scrolling_text_column_renderer
  import scr_pkg::*;
#(
  parameter int TEXT_MAX     = 64,
  parameter int GRID_COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scr_in_if.sink      in_ch_i,
  scr_out_if.source   out_ch_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LEN_W  = $clog2(TEXT_MAX + 1);
  localparam int WIDE_W = LEN_W + 3;
  localparam int TA_W   = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int COL_W  = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLUMNS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  // Configuration registers.
  scr_cfg_t cfg;

  scr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective message length and scroll period. A zero length counts as one
  // character, a length beyond the store counts as the full store, and a zero
  // scroll step counts as one millisecond.
  logic [LEN_W-1:0]  eff_len;
  logic [WIDE_W-1:0] wide;
  logic [15:0]       step;

  always_comb begin
    if (cfg.text_length == 7'd0) begin
      eff_len = LEN_W'(1);
    end else if (32'(cfg.text_length) > TEXT_MAX) begin
      eff_len = LEN_W'(TEXT_MAX);
    end else begin
      eff_len = LEN_W'(cfg.text_length);
    end
    wide = {eff_len, 3'b000};
    step = (cfg.ms_per_pixel == 16'd0) ? 16'd1 : cfg.ms_per_pixel;
  end

  // Input decode. Items are taken only while the sequencer is idle.
  state_e state_q;
  logic   in_acc;
  logic   text_we;
  logic   font_we;
  logic   render_go;

  assign in_ch_i.ready = (state_q == S_IDLE);
  assign in_acc        = in_ch_i.valid && in_ch_i.ready;

  always_comb begin
    text_we   = 1'b0;
    font_we   = 1'b0;
    render_go = 1'b0;
    case (in_ch_i.opcode)
      OP_WRITE_TEXT: text_we   = in_acc && (32'(in_ch_i.address) < TEXT_MAX);
      OP_WRITE_FONT: font_we   = in_acc;
      OP_RENDER:     render_go = in_acc;
      default: ;
    endcase
  end

  // Scroll offset: (timestamp / step) mod (8 * length).
  logic              div_done;
  logic [WIDE_W-1:0] div_offset;

  scr_divmod #(
    .MOD_W (WIDE_W)
  ) u_divmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (render_go),
    .dividend_i (in_ch_i.timestamp_ms),
    .divisor_i  (step),
    .modulus_i  (wide),
    .done_o     (div_done),
    .result_o   (div_offset)
  );

  // Column sequencer. pix_q is the message pixel column shown in grid column
  // col_q; it wraps at the message width.
  logic [WIDE_W-1:0] pix_q;
  logic [COL_W-1:0]  col_q;
  logic [WIDE_W:0]   pix_inc;
  logic              issue;
  logic              issue_last;

  logic [CNT_W-1:0]  fifo_cnt_q;
  logic              s1_valid_q;
  logic              s2_valid_q;
  logic [CNT_W:0]    credit_used;

  // Every fetched column has a reserved queue slot before it is issued.
  assign credit_used = (CNT_W + 1)'(fifo_cnt_q) + (CNT_W + 1)'(s1_valid_q)
                     + (CNT_W + 1)'(s2_valid_q);
  assign issue       = (state_q == S_EMIT) && (credit_used < (CNT_W + 1)'(FIFO_DEPTH));
  assign issue_last  = issue && (col_q == COL_LAST);
  assign pix_inc     = {1'b0, pix_q} + (WIDE_W + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pix_q   <= '0;
      col_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (render_go) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_EMIT;
            pix_q   <= div_offset;
            col_q   <= '0;
          end
        end
        S_EMIT: begin
          if (issue) begin
            pix_q <= (pix_inc == {1'b0, wide}) ? '0 : pix_inc[WIDE_W-1:0];
            col_q <= col_q + COL_W'(1);
            if (issue_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Stage 1: text store read of the character under this column.
  logic [7:0]       text_rdata;
  logic [COL_W-1:0] s1_col_q;
  logic [2:0]       s1_chcol_q;
  logic             s1_last_q;

  scr_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_MAX)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (TA_W'(in_ch_i.address)),
    .wdata_i (in_ch_i.data),
    .re_i    (issue),
    .raddr_i (TA_W'(pix_q >> 3)),
    .rdata_o (text_rdata)
  );

  // Stage 2: font store read of the glyph column mask.
  logic [7:0]       font_rdata;
  logic [COL_W-1:0] s2_col_q;
  logic             s2_last_q;

  scr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (in_ch_i.address),
    .wdata_i (in_ch_i.data),
    .re_i    (s1_valid_q),
    .raddr_i ({text_rdata, s1_chcol_q}),
    .rdata_o (font_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_col_q   <= col_q;
      s1_chcol_q <= pix_q[2:0];
      s1_last_q  <= issue_last;
    end
    if (s1_valid_q) begin
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Output queue. It decouples the fetch pipeline from the consumer so that
  // a column may finish while an earlier one still waits to be taken.
  scr_entry_t       fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic             push;
  logic             pop;
  scr_entry_t       head;

  assign push = s2_valid_q;
  assign pop  = out_ch_o.valid && out_ch_o.ready;
  assign head = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{column: 6'(s2_col_q), mask: font_rdata, last: s2_last_q};
    end
  end

  // A lit row shows its rainbow color, an unlit row is black.
  assign out_ch_o.valid       = (fifo_cnt_q != '0);
  assign out_ch_o.column      = head.column;
  assign out_ch_o.last_column = head.last;
  assign out_ch_o.row0_rgb    = head.mask[0] ? ROW_PALETTE[0] : 24'd0;
  assign out_ch_o.row1_rgb    = head.mask[1] ? ROW_PALETTE[1] : 24'd0;
  assign out_ch_o.row2_rgb    = head.mask[2] ? ROW_PALETTE[2] : 24'd0;
  assign out_ch_o.row3_rgb    = head.mask[3] ? ROW_PALETTE[3] : 24'd0;
  assign out_ch_o.row4_rgb    = head.mask[4] ? ROW_PALETTE[4] : 24'd0;
  assign out_ch_o.row5_rgb    = head.mask[5] ? ROW_PALETTE[5] : 24'd0;
  assign out_ch_o.row6_rgb    = head.mask[6] ? ROW_PALETTE[6] : 24'd0;
  assign out_ch_o.row7_rgb    = head.mask[7] ? ROW_PALETTE[7] : 24'd0;

`ifndef SYNTH
  // Queued plus in-flight columns never exceed the queue depth.
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_used <= (CNT_W + 1)'(FIFO_DEPTH))
    else $error("output queue over-committed");

  // The divider only finishes while the sequencer waits for it.
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  // The scroll offset always lies inside the message width.
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> div_offset < wide)
    else $error("scroll offset out of range");

  // Issuing the final column returns the sequencer to idle.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_last |=> state_q == S_IDLE)
    else $error("sequencer did not end after the final column");
`endif

endmodule

/* verif/scr_column_checker.sv */
module scr_column_checker
  import scr_pkg::*;
#(
  parameter int TEXT_MAX     = 64,
  parameter int GRID_COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scr_in_if           in_ch,
  scr_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          error_count,
  output int          columns_pending
);

  typedef struct packed {
    logic [5:0]       column;
    logic [7:0][23:0] rgb;
    logic             last;
  } grid_column_t;

  logic [7:0]   text_mem  [TEXT_MAX];
  logic [7:0]   glyph_mem [FONT_DEPTH];
  logic [6:0]   text_length;
  logic [15:0]  ms_per_pixel;
  grid_column_t frame_column_q [$];
  int           errors;

  // Works out the scroll offset and queues one expected column per grid column.
  task automatic predict_frame(input logic [31:0] stamp);
    int           len_eff;
    logic [31:0]  scroll_step;
    logic [31:0]  span;
    logic [31:0]  offset;
    logic [31:0]  pix;
    logic [7:0]   mask;
    grid_column_t col;
    len_eff = (text_length == 7'd0) ? 1 : int'(text_length);
    if (len_eff > TEXT_MAX) len_eff = TEXT_MAX;
    scroll_step = (ms_per_pixel == 16'd0) ? 32'd1 : {16'd0, ms_per_pixel};
    span = 32'(8 * len_eff);
    offset = (stamp / scroll_step) % span;
    for (int i = 0; i < GRID_COLUMNS; i++) begin
      pix  = (offset + 32'(i)) % span;
      mask = glyph_mem[{text_mem[pix / 8], pix[2:0]}];
      col.column = 6'(i);
      col.last   = (i == GRID_COLUMNS - 1);
      for (int j = 0; j < 8; j++) begin
        col.rgb[j] = mask[j] ? ROW_PALETTE[j] : 24'd0;
      end
      frame_column_q.push_back(col);
    end
  endtask

  task automatic check_column();
    grid_column_t     want;
    logic [7:0][23:0] got_rgb;
    got_rgb = {out_ch.row7_rgb, out_ch.row6_rgb, out_ch.row5_rgb, out_ch.row4_rgb,
               out_ch.row3_rgb, out_ch.row2_rgb, out_ch.row1_rgb, out_ch.row0_rgb};
    if (frame_column_q.size() == 0) begin
      $error("unexpected column transaction: column %0d", out_ch.column);
      errors++;
      return;
    end
    want = frame_column_q.pop_front();
    if (out_ch.column !== want.column) begin
      $error("column: expected %0d, got %0d", want.column, out_ch.column);
      errors++;
    end
    for (int j = 0; j < 8; j++) begin
      if (got_rgb[j] !== want.rgb[j]) begin
        $error("row%0d_rgb: expected %06h, got %06h", j, want.rgb[j], got_rgb[j]);
        errors++;
      end
    end
    if (out_ch.last_column !== want.last) begin
      $error("last_column: expected %0b, got %0b", want.last, out_ch.last_column);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_length  = TEXT_LENGTH_RST;
      ms_per_pixel = MS_PER_PIXEL_RST;
      frame_column_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TEXT_LENGTH) begin
          text_length = pwdata[6:0];
        end else begin
          ms_per_pixel = pwdata[15:0];
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (scr_op_e'(in_ch.opcode))
          OP_WRITE_TEXT: begin
            if (in_ch.address < TEXT_MAX) text_mem[in_ch.address] = in_ch.data;
          end
          OP_WRITE_FONT: glyph_mem[in_ch.address] = in_ch.data;
          OP_RENDER:     predict_frame(in_ch.timestamp_ms);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) check_column();
    end
    error_count     <= errors;
    columns_pending <= frame_column_q.size();
  end

endmodule

/* verif/tb_scrolling_text_column_renderer.sv */
module tb_scrolling_text_column_renderer;
  import scr_pkg::*;

  localparam int TEXT_MAX     = 64;
  localparam int GRID_COLUMNS = 16;

  // The drain after the last expected column covers a whole render inside the
  // block with some margin.
  localparam int DRAIN_CYCLES     = 34 + GRID_COLUMNS + 10;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS      = 28;
  localparam int LIMIT_CYCLES     = 1000000;

  // Glyph column masks for the directed part: all lit, all dark, single rows at
  // both ends, alternating patterns and half-lit patterns.
  localparam logic [7:0] EDGE_MASKS [8] = '{
    8'hFF, 8'h00, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  scr_in_if  in_ch ();
  scr_out_if out_ch ();

  int error_count;
  int columns_pending;

  // Idling of both sides, in percent of cycles, set per phase.
  int send_idle_pct;
  int recv_stall_pct;
  // Set by the stimulus to make the consumer hold off for a long stretch.
  bit hold_req;
  // Load and render transactions the block acts on; ignored ones do not count.
  int items_sent;

  // What the stimulus knows has been written, so that a render never reads a
  // text entry or a glyph column that still holds garbage from reset.
  bit         text_ok     [TEXT_MAX];
  bit         font_ok     [FONT_DEPTH];
  bit         glyph_ready [256];
  logic [7:0] glyph_codes [$];

  scrolling_text_column_renderer #(
    .TEXT_MAX    (TEXT_MAX),
    .GRID_COLUMNS(GRID_COLUMNS)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scr_column_checker #(
    .TEXT_MAX    (TEXT_MAX),
    .GRID_COLUMNS(GRID_COLUMNS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .error_count    (error_count),
    .columns_pending(columns_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The run must never take longer than this, however slow the handshakes get.
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("Some tests failed");
    $finish;
  end

  // Consumer side. It stalls at the rate of the current phase, and on request
  // holds off for a long counted stretch so that the output queue fills and the
  // block has to stall its input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ch.ready <= int'($urandom_range(99)) >= recv_stall_pct;
    end
  end

  // Offers one transaction and returns at the clock edge that accepts it. Idle
  // cycles go in front of it at the rate of the current phase. The stimulus
  // bookkeeping is updated for what the block will actually store.
  task automatic send_item(input scr_op_e op, input logic [10:0] addr,
                           input logic [7:0] data, input logic [31:0] stamp);
    logic [7:0] code;
    bit         full;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.address      <= addr;
    in_ch.data         <= data;
    in_ch.timestamp_ms <= stamp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    case (op)
      OP_WRITE_TEXT: begin
        // Writes past the end of the text store are dropped by the block.
        if (addr < TEXT_MAX) begin
          text_ok[addr] = 1'b1;
          items_sent++;
        end
      end
      OP_WRITE_FONT: begin
        font_ok[addr] = 1'b1;
        items_sent++;
        code = addr[10:3];
        full = 1'b1;
        for (int c = 0; c < 8; c++) full &= font_ok[{code, 3'(c)}];
        // A glyph may be placed in the text once all eight columns are known.
        if (full && !glyph_ready[code]) begin
          glyph_ready[code] = 1'b1;
          glyph_codes.push_back(code);
        end
      end
      OP_RENDER: items_sent++;
      default: ;
    endcase
  endtask

  // Register write over the configuration port: setup phase, access phase, and
  // an idle phase with psel low so that back-to-back writes never clash on psel.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering transactions, waits for every expected column to arrive and
  // then lets the block settle, since trailing loads cause no column.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (columns_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_code();
    return glyph_codes[$urandom_range(glyph_codes.size() - 1)];
  endfunction

  // Timestamps near zero, near the top of the 32-bit range, and anywhere.
  function automatic logic [31:0] random_stamp();
    case ($urandom_range(3))
      0:       return 32'($urandom_range(4095));
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(4095));
      default: return $urandom;
    endcase
  endfunction

  // Writes both registers while the block is idle, then fills every text entry
  // that the new length brings into view with a code whose glyph is complete.
  task automatic configure(input logic [6:0] length, input logic [15:0] scroll_ms);
    int chars;
    write_reg(REG_TEXT_LENGTH, {25'd0, length});
    write_reg(REG_MS_PER_PIXEL, {16'd0, scroll_ms});
    chars = (length == 7'd0) ? 1 : int'(length);
    if (chars > TEXT_MAX) chars = TEXT_MAX;
    for (int a = 0; a < chars; a++) begin
      if (!text_ok[a]) send_item(OP_WRITE_TEXT, 11'(a), pick_code(), $urandom);
    end
  endtask

  // One random step: renders most often, text edits with known glyphs and whole
  // glyph loads, with loose font writes and ignored transactions as noise.
  task automatic random_item();
    int         pick;
    logic [7:0] code;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_item(OP_RENDER, 11'($urandom), 8'($urandom), random_stamp());
    end else if (pick < 55) begin
      send_item(OP_WRITE_TEXT, 11'($urandom_range(TEXT_MAX - 1)), pick_code(), $urandom);
    end else if (pick < 65) begin
      code = 8'($urandom);
      for (int c = 0; c < 8; c++) begin
        send_item(OP_WRITE_FONT, {code, 3'(c)}, 8'($urandom), $urandom);
      end
    end else if (pick < 80) begin
      send_item(OP_WRITE_FONT, 11'($urandom), 8'($urandom), $urandom);
    end else if (pick < 90) begin
      send_item(OP_WRITE_TEXT, 11'($urandom_range(2047, TEXT_MAX)), 8'($urandom), $urandom);
    end else begin
      send_item(OP_UNUSED, 11'($urandom), 8'($urandom), $urandom);
    end
  endtask

  initial begin
    int goal;

    // Every input is known from time zero, with reset asserted first.
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_WRITE_TEXT;
    in_ch.address      <= '0;
    in_ch.data         <= '0;
    in_ch.timestamp_ms <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    items_sent     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset register values (one character, 125 ms per
    // pixel). Glyph 0xFF occupies the very top of the font address space.
    for (int c = 0; c < 8; c++) begin
      send_item(OP_WRITE_FONT, {8'hFF, 3'(c)}, EDGE_MASKS[c], 32'd0);
    end
    send_item(OP_WRITE_TEXT, 11'd0, 8'hFF, 32'd0);
    send_item(OP_RENDER, 11'd0, 8'd0, 32'd0);
    send_item(OP_RENDER, 11'h7FF, 8'hFF, 32'hFFFF_FFFF);
    // Offset 7 puts the last glyph column first and wraps the rest around.
    send_item(OP_RENDER, 11'd0, 8'd0, 32'd875);
    // The unused opcode and text writes past the store must change nothing.
    send_item(OP_UNUSED, 11'h7FF, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_WRITE_TEXT, 11'(TEXT_MAX), 8'h00, 32'd0);
    send_item(OP_WRITE_TEXT, 11'h7FF, 8'h00, 32'd0);
    // Glyph 0x00 sits at the bottom of the font address space.
    for (int c = 0; c < 8; c++) begin
      send_item(OP_WRITE_FONT, {8'h00, 3'(c)}, 8'($urandom), 32'd0);
    end
    send_item(OP_RENDER, 11'd0, 8'd0, 32'd0);
    wait_idle();

    // Random phases. The first ones cover the register extremes: a zero length
    // and zero step (both read as one), the full message at the slowest scroll,
    // a length past the store size at the fastest scroll, and a single glyph.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(7'd0, 16'd0);
        1: configure(7'(TEXT_MAX), 16'hFFFF);
        2: configure(7'h7F, 16'd1);
        3: configure(7'd1, 16'd1);
        default: begin
          configure(7'($urandom_range(TEXT_MAX, 1)),
                    16'($urandom_range(1) ? $urandom_range(300, 1) :
                                            $urandom_range(65535, 1)));
        end
      endcase

      // Idling cycles through: none, busy producer side gaps, busy consumer
      // stalls, and light idling on both sides at once.
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase

      // Back pressure: the consumer holds off while renders keep coming, so the
      // output queue fills and the input handshake has to stall.
      if (p == 5) begin
        hold_req = 1'b1;
        repeat (6) send_item(OP_RENDER, 11'($urandom), 8'($urandom), random_stamp());
      end

      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) random_item();
      wait_idle();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/scr_pkg.sv
rtl/scr_chan_if.sv
rtl/scr_ram.sv
rtl/scr_apb_regs.sv
rtl/scr_divmod.sv
rtl/scrolling_text_column_renderer.sv
verif/scr_column_checker.sv
verif/tb_scrolling_text_column_renderer.sv
